### design/hdg_pkg.sv
// Shared constants, types and arctangent table builder for the compass heading block.
// Used by hdg_prenorm, hdg_cordic, hdg_scale and compass_heading_atan2; no dependencies.
`default_nettype none

package hdg_pkg;

    // Output format: degrees with FRACTION_BITS fraction bits
    localparam int unsigned FRACTION_BITS = 7;
    localparam int unsigned READING_W     = 16;
    localparam int unsigned BEARING_W     = 16;
    localparam int unsigned DATA_W        = 64;
    localparam int unsigned SHIFT_W       = 6;
    localparam int unsigned CORDIC_STEPS  = 60;

    // Normalised magnitude sits in [2^58, 2^59)
    localparam int unsigned NORM_MSB      = 58;

    // 360 degrees in output units
    localparam logic [BEARING_W-1:0] FULL_TURN = BEARING_W'(360 << FRACTION_BITS);

    // 2*pi in Q61 radians
    localparam logic [63:0] TWO_PI_Q61 = 64'hC90FDAA22168C234;

    // Control that travels alongside each item
    typedef struct packed {
        logic valid;
        logic zero;
    } hdg_ctrl_t;

    // Long division of a 64-bit value by a small integer, bit by bit
    function automatic logic [63:0] div_small(input logic [63:0] num, input int unsigned den);
        logic [63:0] q;
        logic [63:0] r;
        q = '0;
        r = '0;
        for (int b = 63; b >= 0; b--)
        begin
            r = {r[62:0], num[b]};
            if (r >= 64'(den))
            begin
                r    = r - 64'(den);
                q[b] = 1'b1;
            end
        end
        return q;
    endfunction

    // Q61 radians (below 2*pi) to a fraction of a full turn scaled by 2^64
    function automatic logic [63:0] rad_to_turn(input logic [63:0] a);
        logic [63:0] r;
        logic [63:0] q;
        logic        carry;
        r = a;
        q = '0;
        for (int b = 0; b < 64; b++)
        begin
            carry = r[63];
            r     = r << 1;
            q     = q << 1;
            if (carry || (r >= TWO_PI_Q61))
            begin
                r    = r - TWO_PI_Q61;
                q[0] = 1'b1;
            end
        end
        return q;
    endfunction

    // atan(2^-idx) in units of 2^-64 of a turn, from the arctangent series
    function automatic logic [63:0] turn_angle(input int unsigned idx);
        logic [63:0] sum;
        logic [63:0] term;
        logic        add;
        sum = '0;
        add = 1'b1;
        if (idx == 0)
        begin
            return 64'd1 << 61;
        end
        for (int unsigned k = 1; idx * k <= 61; k += 2)
        begin
            term = div_small(64'd1 << (61 - idx * k), k);
            sum  = add ? (sum + term) : (sum - term);
            add  = ~add;
        end
        return rad_to_turn(sum);
    endfunction

endpackage

`default_nettype wire

### design/hdg_prenorm.sv
// Front end: registers the reading, finds the normalising shift, folds the
// left half-plane and shifts X and Y up. Three register stages. Uses hdg_pkg.
`default_nettype none

module hdg_prenorm
(
    input  wire logic                                    clk,
    input  wire logic                                    rst_n,
    input  wire logic                                    en,
    input  wire logic                                    in_valid,
    input  wire logic signed [hdg_pkg::READING_W-1:0]    x_in,
    input  wire logic signed [hdg_pkg::READING_W-1:0]    y_in,
    output hdg_pkg::hdg_ctrl_t                           ctrl_out,
    output logic signed [hdg_pkg::DATA_W-1:0]            x_out,
    output logic signed [hdg_pkg::DATA_W-1:0]            y_out,
    output logic        [hdg_pkg::DATA_W-1:0]            a_out
);

    localparam int unsigned RW = hdg_pkg::READING_W;
    localparam int unsigned DW = hdg_pkg::DATA_W;
    localparam int unsigned SW = hdg_pkg::SHIFT_W;

    // Stage 1: captured reading
    logic                 v1_reg;
    logic signed [RW-1:0] x1_reg;
    logic signed [RW-1:0] y1_reg;

    // Stage 2: magnitudes, shift count, folded Y
    hdg_pkg::hdg_ctrl_t   c2_reg;
    hdg_pkg::hdg_ctrl_t   c2_next;
    logic [RW-1:0]        ax2_reg;
    logic [RW-1:0]        ax2_next;
    logic signed [RW:0]   yn2_reg;
    logic signed [RW:0]   yn2_next;
    logic [SW-1:0]        s2_reg;
    logic [SW-1:0]        s2_next;
    logic                 neg2_reg;

    // Stage 3: shifted vector and starting angle
    hdg_pkg::hdg_ctrl_t   c3_reg;
    logic signed [DW-1:0] x3_reg;
    logic signed [DW-1:0] x3_next;
    logic signed [DW-1:0] y3_reg;
    logic signed [DW-1:0] y3_next;
    logic [DW-1:0]        a3_reg;
    logic [DW-1:0]        a3_next;

    logic signed [RW:0]   xe;
    logic signed [RW:0]   ye;
    logic signed [RW:0]   ax17;
    logic signed [RW:0]   ay17;
    logic [RW-1:0]        ay;
    logic [RW-1:0]        mag;
    logic [3:0]           msb;

    // Absolute values, larger magnitude and its leading one
    always_comb
    begin
        xe       = {x1_reg[RW-1], x1_reg};
        ye       = {y1_reg[RW-1], y1_reg};
        ax17     = x1_reg[RW-1] ? -xe : xe;
        ay17     = y1_reg[RW-1] ? -ye : ye;
        ax2_next = ax17[RW-1:0];
        ay       = ay17[RW-1:0];
        mag      = (ax2_next > ay) ? ax2_next : ay;
        msb      = '0;
        for (int b = 0; b < RW; b++)
        begin
            if (mag[b])
            begin
                msb = 4'(b);
            end
        end
        s2_next       = SW'(hdg_pkg::NORM_MSB) - {2'b00, msb};
        // a vector in the left half-plane is turned by half a turn: negate Y
        yn2_next      = x1_reg[RW-1] ? -ye : ye;
        c2_next.valid = v1_reg;
        c2_next.zero  = (x1_reg == '0) && (y1_reg == '0);
    end

    // Shift both components up to the normalised range
    always_comb
    begin
        x3_next = DW'(ax2_reg) << s2_reg;
        y3_next = {{(DW-RW-1){yn2_reg[RW]}}, yn2_reg} << s2_reg;
        a3_next = neg2_reg ? (DW'(1) << (DW-1)) : '0;
    end

    // Advance the control through all three stages
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            c2_reg <= '0;
            c3_reg <= '0;
        end
        else if (en)
        begin
            v1_reg <= in_valid;
            c2_reg <= c2_next;
            c3_reg <= c2_reg;
        end
    end

    // Advance the payload
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            x1_reg   <= x_in;
            y1_reg   <= y_in;
            ax2_reg  <= ax2_next;
            yn2_reg  <= yn2_next;
            s2_reg   <= s2_next;
            neg2_reg <= x1_reg[RW-1];
            x3_reg   <= x3_next;
            y3_reg   <= y3_next;
            a3_reg   <= a3_next;
        end
    end

    assign ctrl_out = c3_reg;
    assign x_out    = x3_reg;
    assign y_out    = y3_reg;
    assign a_out    = a3_reg;

endmodule

`default_nettype wire

### design/hdg_cordic.sv
// Vectoring CORDIC: one micro-rotation per register stage, 60 stages.
// Angle table built at elaboration from hdg_pkg::turn_angle. Uses hdg_pkg.
`default_nettype none

module hdg_cordic
(
    input  wire logic                                    clk,
    input  wire logic                                    rst_n,
    input  wire logic                                    en,
    input  wire hdg_pkg::hdg_ctrl_t                      ctrl_in,
    input  wire logic signed [hdg_pkg::DATA_W-1:0]       x_in,
    input  wire logic signed [hdg_pkg::DATA_W-1:0]       y_in,
    input  wire logic        [hdg_pkg::DATA_W-1:0]       a_in,
    output hdg_pkg::hdg_ctrl_t                           ctrl_out,
    output logic             [hdg_pkg::DATA_W-1:0]       a_out
);

    localparam int unsigned DW = hdg_pkg::DATA_W;
    localparam int unsigned N  = hdg_pkg::CORDIC_STEPS;

    // Stage boundaries: entry 0 is the input, entry i+1 the register of stage i
    hdg_pkg::hdg_ctrl_t   c_pipe [N+1];
    logic signed [DW-1:0] x_pipe [N+1];
    logic signed [DW-1:0] y_pipe [N+1];
    logic [DW-1:0]        a_pipe [N+1];

    assign c_pipe[0] = ctrl_in;
    assign x_pipe[0] = x_in;
    assign y_pipe[0] = y_in;
    assign a_pipe[0] = a_in;

    for (genvar i = 0; i < N; i++)
    begin : g_stage
        localparam logic [DW-1:0] ANGLE = hdg_pkg::turn_angle(i);

        hdg_pkg::hdg_ctrl_t   c_reg;
        logic signed [DW-1:0] x_reg;
        logic signed [DW-1:0] x_next;
        logic signed [DW-1:0] y_reg;
        logic signed [DW-1:0] y_next;
        logic [DW-1:0]        a_reg;
        logic [DW-1:0]        a_next;
        logic signed [DW-1:0] dx;
        logic signed [DW-1:0] dy;

        // Rotate clockwise while Y is non-negative, else anticlockwise
        always_comb
        begin
            dx = x_pipe[i] >>> i;
            dy = y_pipe[i] >>> i;
            if (!y_pipe[i][DW-1])
            begin
                x_next = x_pipe[i] + dy;
                y_next = y_pipe[i] - dx;
                a_next = a_pipe[i] + ANGLE;
            end
            else
            begin
                x_next = x_pipe[i] - dy;
                y_next = y_pipe[i] + dx;
                a_next = a_pipe[i] - ANGLE;
            end
        end

        // Hold control across the stall
        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                c_reg <= '0;
            end
            else if (en)
            begin
                c_reg <= c_pipe[i];
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                x_reg <= x_next;
                y_reg <= y_next;
                a_reg <= a_next;
            end
        end

        assign c_pipe[i+1] = c_reg;
        assign x_pipe[i+1] = x_reg;
        assign y_pipe[i+1] = y_reg;
        assign a_pipe[i+1] = a_reg;
    end

    // The final X and Y components are not needed beyond the last stage
    assign ctrl_out = c_pipe[N];
    assign a_out    = a_pipe[N];

endmodule

`default_nettype wire

### design/hdg_scale.sv
// Back end: turns the turn fraction into degrees, rounds half up and wraps
// 360 to 0. Three register stages: multiply, sum and round, wrap. Uses hdg_pkg.
`default_nettype none

module hdg_scale
(
    input  wire logic                                    clk,
    input  wire logic                                    rst_n,
    input  wire logic                                    en,
    input  wire hdg_pkg::hdg_ctrl_t                      ctrl_in,
    input  wire logic [hdg_pkg::DATA_W-1:0]              a_in,
    output hdg_pkg::hdg_ctrl_t                           ctrl_out,
    output logic      [hdg_pkg::BEARING_W-1:0]           bearing_out
);

    localparam int unsigned HW = hdg_pkg::DATA_W / 2;
    localparam int unsigned BW = hdg_pkg::BEARING_W;
    localparam int unsigned PW = HW + BW;
    localparam int unsigned SUM_W = PW + 1;

    // Stage 1: partial products of the high and low halves
    hdg_pkg::hdg_ctrl_t c1_reg;
    logic [PW-1:0]      ph1_reg;
    logic [PW-1:0]      pl1_reg;

    // Stage 2: sum with the rounding constant
    hdg_pkg::hdg_ctrl_t c2_reg;
    logic [SUM_W-1:0]   sum2_reg;
    logic [SUM_W-1:0]   sum2_next;

    // Stage 3: wrapped bearing
    hdg_pkg::hdg_ctrl_t c3_reg;
    logic [BW-1:0]      res3_reg;
    logic [BW-1:0]      res3_next;
    logic [SUM_W-HW-1:0] res_wide;

    always_comb
    begin
        sum2_next = SUM_W'(ph1_reg) + SUM_W'(pl1_reg >> HW) + (SUM_W'(1) << (HW-1));
    end

    // Drop the fraction, then force zero for a null vector or a full turn
    always_comb
    begin
        res_wide = sum2_reg[SUM_W-1:HW];
        if (c2_reg.zero || (res_wide >= (SUM_W-HW)'(hdg_pkg::FULL_TURN)))
        begin
            res3_next = '0;
        end
        else
        begin
            res3_next = res_wide[BW-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            c1_reg <= '0;
            c2_reg <= '0;
            c3_reg <= '0;
        end
        else if (en)
        begin
            c1_reg <= ctrl_in;
            c2_reg <= c1_reg;
            c3_reg <= c2_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            ph1_reg  <= PW'(a_in[2*HW-1:HW]) * PW'(hdg_pkg::FULL_TURN);
            pl1_reg  <= PW'(a_in[HW-1:0]) * PW'(hdg_pkg::FULL_TURN);
            sum2_reg <= sum2_next;
            res3_reg <= res3_next;
        end
    end

    assign ctrl_out    = c3_reg;
    assign bearing_out = res3_reg;

endmodule

`default_nettype wire

### design/compass_heading_atan2.sv
// Top level of the compass heading block: front end, CORDIC, scaling and an
// output register with skid stage. Uses hdg_pkg, hdg_prenorm, hdg_cordic, hdg_scale.
//
//   Channel   Direction  Payload (lowest bit first)
//   s_axis    in         tdata[15:0] x_reading, tdata[31:16] y_reading
//   m_axis    out        tdata[15:0] bearing_deg
//
// A reading is taken in every cycle while the skid stage is empty. From transfer in
// to result valid it passes 3 front-end stages, 60 CORDIC stages, 3 scaling stages
// and 1 output register. The 60-stage micro-rotation pipeline sets the latency.
// Reset clears every valid bit; no state survives between readings.
// A stall on m_axis fills the skid stage; s_axis tready then drops and the
// whole pipeline holds until the skid stage empties.
`default_nettype none

module compass_heading_atan2
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [31:0] s_axis_tdata,   // [15:0] x_reading, [31:16] y_reading
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic [15:0]      m_axis_tdata    // [15:0] bearing_deg
);

    localparam int unsigned RW = hdg_pkg::READING_W;
    localparam int unsigned DW = hdg_pkg::DATA_W;
    localparam int unsigned BW = hdg_pkg::BEARING_W;

    logic                 en;
    hdg_pkg::hdg_ctrl_t   pre_ctrl;
    logic signed [DW-1:0] pre_x;
    logic signed [DW-1:0] pre_y;
    logic [DW-1:0]        pre_a;
    hdg_pkg::hdg_ctrl_t   cor_ctrl;
    logic [DW-1:0]        cor_a;
    hdg_pkg::hdg_ctrl_t   scl_ctrl;
    logic [BW-1:0]        scl_bearing;

    logic                 out_valid_reg;
    logic                 out_valid_next;
    logic [BW-1:0]        out_data_reg;
    logic                 skid_valid_reg;
    logic                 skid_valid_next;
    logic [BW-1:0]        skid_data_reg;
    logic                 take;
    logic                 arrive;

    // Whole pipeline moves while the skid stage is empty
    assign en            = ~skid_valid_reg;
    assign s_axis_tready = en;

    hdg_prenorm u_prenorm
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .en       (en),
        .in_valid (s_axis_tvalid),
        .x_in     (s_axis_tdata[RW-1:0]),
        .y_in     (s_axis_tdata[2*RW-1:RW]),
        .ctrl_out (pre_ctrl),
        .x_out    (pre_x),
        .y_out    (pre_y),
        .a_out    (pre_a)
    );

    hdg_cordic u_cordic
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .en       (en),
        .ctrl_in  (pre_ctrl),
        .x_in     (pre_x),
        .y_in     (pre_y),
        .a_in     (pre_a),
        .ctrl_out (cor_ctrl),
        .a_out    (cor_a)
    );

    hdg_scale u_scale
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .en          (en),
        .ctrl_in     (cor_ctrl),
        .a_in        (cor_a),
        .ctrl_out    (scl_ctrl),
        .bearing_out (scl_bearing)
    );

    // Output register and skid stage
    assign take   = out_valid_reg & m_axis_tready;
    assign arrive = en & scl_ctrl.valid;

    always_comb
    begin
        skid_valid_next = skid_valid_reg;
        out_valid_next  = out_valid_reg & ~take;
        if (skid_valid_reg)
        begin
            if (take)
            begin
                skid_valid_next = 1'b0;
                out_valid_next  = 1'b1;
            end
        end
        else if (arrive)
        begin
            if (out_valid_reg && !take)
            begin
                skid_valid_next = 1'b1;
                out_valid_next  = 1'b1;
            end
            else
            begin
                out_valid_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg  <= out_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    // Load the output from the skid stage first, else from the pipeline
    always_ff @(posedge clk)
    begin
        if (skid_valid_reg)
        begin
            if (take)
            begin
                out_data_reg <= skid_data_reg;
            end
        end
        else if (arrive)
        begin
            if (out_valid_reg && !take)
            begin
                skid_data_reg <= scl_bearing;
            end
            else
            begin
                out_data_reg <= scl_bearing;
            end
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;

`ifndef SYNTHESIS
    // Skid stage only holds a result behind a waiting output
    a_skid_behind_out: assert property (@(posedge clk) disable iff (!rst_n)
        skid_valid_reg |-> out_valid_reg)
        else $error("skid stage full with output register empty");

    // Skid stage fills only after a stalled output
    a_skid_fill: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(skid_valid_reg) |-> $past(out_valid_reg && !m_axis_tready))
        else $error("skid stage filled without an output stall");

    // Bearing always below a full turn
    a_bearing_range: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> (m_axis_tdata < hdg_pkg::FULL_TURN))
        else $error("bearing at or above 360 degrees");

    // An item arriving from the pipeline always finds room
    a_no_overrun: assert property (@(posedge clk) disable iff (!rst_n)
        (scl_ctrl.valid && en) |=> out_valid_reg)
        else $error("pipeline result lost at the output");
`endif

endmodule

`default_nettype wire

### tb/tb_top.sv
// Self-checking testbench for compass_heading_atan2: directed and random readings
// against fixed or in-bench CORDIC predicted bearings. Depends on hdg_pkg and the RTL only.
`timescale 1ns / 100ps

module tb_top;

    localparam int CYCLE_LIMIT    = 200000;
    localparam int RANDOM_ITEMS   = 1850;
    localparam int DRAIN_CYCLES   = 100;
    localparam int RW             = hdg_pkg::READING_W;
    localparam int BW             = hdg_pkg::BEARING_W;
    localparam int FB             = hdg_pkg::FRACTION_BITS;
    localparam int NSTEP          = hdg_pkg::CORDIC_STEPS;
    localparam logic [BW-1:0] DEG_45  = BW'(45 << FB);
    localparam logic [BW-1:0] DEG_90  = BW'(90 << FB);
    localparam logic [BW-1:0] DEG_135 = BW'(135 << FB);
    localparam logic [BW-1:0] DEG_180 = BW'(180 << FB);
    localparam logic [BW-1:0] DEG_225 = BW'(225 << FB);
    localparam logic [BW-1:0] DEG_270 = BW'(270 << FB);
    localparam logic [BW-1:0] DEG_315 = BW'(315 << FB);

    typedef struct packed {
        logic signed [RW-1:0] x_reading;
        logic signed [RW-1:0] y_reading;
        logic                 fixed;      // bearing below is known by inspection
        logic [BW-1:0]        bearing;
    } reading_case_t;

    // Directed readings: zero vector, axes, diagonals, full-scale negatives, wrap to 360
    localparam int N_DIRECTED = 20;
    localparam reading_case_t DIRECTED [N_DIRECTED] = '{
        '{16'sd0,      16'sd0,      1'b1, 16'd0},
        '{16'sd1,      16'sd0,      1'b1, 16'd0},
        '{16'sd0,      16'sd1,      1'b1, DEG_90},
        '{-16'sd1,     16'sd0,      1'b1, DEG_180},
        '{16'sd0,      -16'sd1,     1'b1, DEG_270},
        '{16'sd32767,  16'sd0,      1'b1, 16'd0},
        '{-16'sd32768, 16'sd0,      1'b1, DEG_180},
        '{16'sd0,      16'sd32767,  1'b1, DEG_90},
        '{16'sd0,      -16'sd32768, 1'b1, DEG_270},
        '{16'sd32767,  16'sd32767,  1'b1, DEG_45},
        '{-16'sd32768, -16'sd32768, 1'b1, DEG_225},
        '{-16'sd1,     16'sd1,      1'b1, DEG_135},
        '{-16'sd1,     -16'sd1,     1'b1, DEG_225},
        '{16'sd1,      -16'sd1,     1'b1, DEG_315},
        '{16'sd32767,  -16'sd1,     1'b1, 16'd0},
        '{16'sd32767,  -16'sd2,     1'b1, 16'd0},
        '{16'sd32767,  -16'sd3,     1'b0, 16'd0},
        '{-16'sd32768, 16'sd32767,  1'b0, 16'd0},
        '{16'sd32767,  -16'sd32768, 1'b0, 16'd0},
        '{-16'sd12345, 16'sd23456,  1'b0, 16'd0}
    };

    logic                 clk;
    logic                 rst_n;
    logic                 s_axis_tvalid;
    logic                 s_axis_tready;
    logic [31:0]          s_axis_tdata;   // [15:0] x_reading, [31:16] y_reading
    logic                 m_axis_tvalid;
    logic                 m_axis_tready;
    logic [15:0]          m_axis_tdata;   // [15:0] bearing_deg

    logic [63:0]          atan_turn [NSTEP];
    logic [BW-1:0]        bearing_q [$];
    logic                 cur_fixed;
    logic [BW-1:0]        cur_bearing;
    logic                 quiet;
    int                   fail_count;
    int                   cycle_count;

    compass_heading_atan2 dut
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    // Bearing of one reading: normalise, vectoring CORDIC, scale to degrees
    function automatic logic [BW-1:0] predict_bearing(
        input logic signed [RW-1:0] xr,
        input logic signed [RW-1:0] yr);
        logic signed [63:0] vx;
        logic signed [63:0] vy;
        logic signed [63:0] dx;
        logic signed [63:0] dy;
        logic [63:0]        turn;
        logic [16:0]        mag_x;
        logic [16:0]        mag_y;
        logic [16:0]        mag;
        logic [127:0]       scaled;
        int                 sh;
        if (xr == 0 && yr == 0)
        begin
            return '0;
        end
        mag_x = 17'(xr[15] ? -32'(xr) : 32'(xr));
        mag_y = 17'(yr[15] ? -32'(yr) : 32'(yr));
        mag   = (mag_x > mag_y) ? mag_x : mag_y;
        sh    = 0;
        while ((64'(mag) << sh) < (64'd1 << hdg_pkg::NORM_MSB))
        begin
            sh++;
        end
        vx   = 64'(xr) <<< sh;
        vy   = 64'(yr) <<< sh;
        turn = '0;
        // Left half-plane: turn by half a turn first
        if (vx < 0)
        begin
            vx   = -vx;
            vy   = -vy;
            turn = 64'd1 << 63;
        end
        for (int i = 0; i < NSTEP; i++)
        begin
            dx = vx >>> i;
            dy = vy >>> i;
            if (vy >= 0)
            begin
                vx   = vx + dy;
                vy   = vy - dx;
                turn = turn + atan_turn[i];
            end
            else
            begin
                vx   = vx - dy;
                vy   = vy + dx;
                turn = turn - atan_turn[i];
            end
        end
        // Round half up; a bearing that lands on 360 wraps to 0
        scaled = 128'(turn) * 128'(hdg_pkg::FULL_TURN) + (128'd1 << 63);
        if (scaled[127:64] >= 64'(hdg_pkg::FULL_TURN))
        begin
            return '0;
        end
        return BW'(scaled[127:64]);
    endfunction

    // Clock and cycle limit
    initial
    begin
        clk = 1'b0;
    end

    always #1 clk = ~clk;

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("FAILURE");
            $finish;
        end
    end

    // Receiver: drop tready at random, about 8 percent of the time, outside the quiet stretch
    always @(negedge clk)
    begin
        m_axis_tready = rst_n && (quiet || ($urandom_range(0, 99) >= 8));
    end

    // Check each result transfer, then record the expected bearing of each reading transfer
    always @(posedge clk)
    begin
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            if (bearing_q.size() == 0)
            begin
                $display("%0t: unexpected bearing 0x%04h", $time, m_axis_tdata);
                fail_count++;
            end
            else
            begin
                if (m_axis_tdata !== bearing_q[0])
                begin
                    $display("%0t: bearing expected 0x%04h, got 0x%04h",
                             $time, bearing_q[0], m_axis_tdata);
                    fail_count++;
                end
                void'(bearing_q.pop_front());
            end
        end
        if (rst_n && s_axis_tvalid && s_axis_tready)
        begin
            if (cur_fixed)
            begin
                bearing_q.push_back(cur_bearing);
            end
            else
            begin
                bearing_q.push_back(predict_bearing(s_axis_tdata[15:0], s_axis_tdata[31:16]));
            end
        end
    end

    // Present one reading and hold it until the transfer
    task automatic send_reading(input logic [RW-1:0] xr, input logic [RW-1:0] yr,
                                input logic fixed, input logic [BW-1:0] bearing);
        @(negedge clk);
        while (!quiet && ($urandom_range(0, 99) < 8))
        begin
            s_axis_tvalid = 1'b0;
            @(negedge clk);
        end
        s_axis_tvalid = 1'b1;
        s_axis_tdata  = {yr, xr};
        cur_fixed     = fixed;
        cur_bearing   = bearing;
        @(posedge clk);
        while (!s_axis_tready)
        begin
            @(posedge clk);
        end
    endtask

    // Random reading, weighted towards axes, diagonals, extremes and small vectors
    task automatic send_random_reading();
        logic [RW-1:0] xr;
        logic [RW-1:0] yr;
        logic [RW-1:0] extremes [6];
        extremes = '{16'h8000, 16'h8001, 16'hFFFF, 16'h0000, 16'h0001, 16'h7FFF};
        xr = 16'($urandom);
        yr = 16'($urandom);
        case ($urandom_range(0, 9))
            6:
            begin
                xr = 16'($urandom_range(0, 16) - 8);
                yr = 16'($urandom_range(0, 16) - 8);
            end
            7:
            begin
                // Just below or above the positive X axis
                xr = 16'($urandom_range(1000, 32767));
                yr = 16'($urandom_range(0, 8) - 4);
            end
            8:
            begin
                xr = extremes[$urandom_range(0, 5)];
                yr = extremes[$urandom_range(0, 5)];
            end
            9:
            begin
                yr = $urandom_range(0, 1) ? xr : -xr;
            end
            default:
            begin
            end
        endcase
        send_reading(xr, yr, 1'b0, '0);
    endtask

    // Build the arctangent table, reset, then run the directed and random readings
    initial
    begin
        logic [63:0] sum;
        logic [63:0] term;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        m_axis_tready = 1'b0;
        cur_fixed     = 1'b0;
        cur_bearing   = '0;
        quiet         = 1'b0;
        fail_count    = 0;
        cycle_count   = 0;
        rst_n         = 1'b0;

        atan_turn[0] = 64'd1 << 61;
        for (int i = 1; i < NSTEP; i++)
        begin
            sum = '0;
            for (int k = 1; i * k <= 61; k += 2)
            begin
                term = (64'd1 << (61 - i * k)) / 64'(k);
                sum  = ((k >> 1) & 1) ? (sum - term) : (sum + term);
            end
            atan_turn[i] = 64'({sum, 64'd0} / 128'(hdg_pkg::TWO_PI_Q61));
        end

        repeat (12) @(negedge clk);
        rst_n = 1'b1;

        for (int n = 0; n < N_DIRECTED; n++)
        begin
            send_reading(DIRECTED[n].x_reading, DIRECTED[n].y_reading,
                         DIRECTED[n].fixed, DIRECTED[n].bearing);
        end

        for (int n = 0; n < RANDOM_ITEMS; n++)
        begin
            quiet = (n >= 700) && (n < 1100);
            // Hold off once until the pipeline has fully drained
            if (n == 1300)
            begin
                @(negedge clk);
                s_axis_tvalid = 1'b0;
                while (bearing_q.size() != 0)
                begin
                    @(negedge clk);
                end
            end
            send_random_reading();
        end

        @(negedge clk);
        s_axis_tvalid = 1'b0;
        while (bearing_q.size() != 0)
        begin
            @(negedge clk);
        end
        repeat (DRAIN_CYCLES) @(negedge clk);

        if (fail_count == 0)
        begin
            $display("SUCCESS");
        end
        else
        begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule

### compass_heading_atan2.f
design/hdg_pkg.sv
design/hdg_prenorm.sv
design/hdg_cordic.sv
design/hdg_scale.sv
design/compass_heading_atan2.sv
tb/tb_top.sv
